@@ hw/rtl/uscsw_pkg.sv @@
// Package for the spherical cap sample warp: shared constants.
// Depends on nothing; used by the front, back and top-level modules.
package uscsw_pkg;

  localparam int AngleTableLen = 30;
  localparam logic [63:0] GainQ32 = 64'd2608131496;

  localparam logic [31:0] AtanTurnsQ32 [AngleTableLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  localparam logic signed [17:0] CapMax = 18'sd65536;
  localparam logic signed [17:0] CapMin = -18'sd65536;

endpackage

@@ hw/rtl/uscsw_front.sv @@
// Front part: takes a word, computes height z and the square-root radius.
// Uses uscsw_pkg. Pipelined: rescale, product, radicand, then one sqrt digit per stage.
module uscsw_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic signed [17:0]          cap_cos,
  input  logic [15:0]                 u_height,
  input  logic [15:0]                 u_azimuth,
  output logic                        out_vld,
  output logic signed [FRAC_BITS+1:0] z_out,
  output logic [FRAC_BITS:0]          r_out,
  output logic [15:0]                 azim_out
);
  localparam int F   = FRAC_BITS;
  localparam int ZW  = F + 2;
  localparam int SQW = 2 * F + 2;
  localparam int RW  = F + 1;
  localparam int NS  = (SQW + 1) / 2;
  localparam logic signed [ZW-1:0] ONE = ZW'(1) <<< F;
  localparam logic signed [17:0] CapMaxL = uscsw_pkg::CapMax;
  localparam logic signed [17:0] CapMinL = uscsw_pkg::CapMin;

  function automatic logic signed [ZW-1:0] rescale16(input logic signed [17:0] v);
    logic [17:0] mag;
    logic [17:0] rm;
    rm = '0;
    mag = v[17] ? 18'(-v) : 18'(v);
    if (F >= 16) begin
      return ZW'(v) <<< (F - 16);
    end else begin
      rm = 18'((mag + (18'd1 << (15 - F))) >> (16 - F));
      return v[17] ? -ZW'(rm) : ZW'(rm);
    end
  endfunction

  // stage 0: scaled operands
  logic               s0_vld_r;
  logic [ZW-1:0]      s0_span_r;
  logic [F:0]         s0_u_r;
  logic [15:0]        s0_az_r;
  // stage 1: z
  logic               s1_vld_r;
  logic signed [ZW-1:0] s1_z_r;
  logic [15:0]        s1_az_r;

  logic signed [17:0] cap_sat;
  logic signed [ZW-1:0] c_scaled;
  logic [2*ZW+1:0]    prod;
  logic signed [2*ZW+1:0] z_wide;

  always_comb begin
    cap_sat = (cap_cos > CapMaxL) ? CapMaxL : ((cap_cos < CapMinL) ? CapMinL : cap_cos);
    c_scaled = rescale16(cap_sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_vld;
      s1_vld_r <= s0_vld_r;
    end
    s0_span_r <= ZW'(ONE - c_scaled);
    // Narrower fractions round the height fraction half up.
    s0_u_r    <= (F >= 16) ? (RW'(u_height) << (F - 16)) :
                 RW'((17'(u_height) + (17'd1 << (15 - F))) >> (16 - F));
    s0_az_r   <= u_azimuth;
    s1_z_r    <= ZW'(z_wide);
    s1_az_r   <= s0_az_r;
  end

  always_comb begin
    prod = (2*ZW+2)'(s0_span_r) * (2*ZW+2)'(s0_u_r);
    z_wide = (2*ZW+2)'(ONE) - (2*ZW+2)'((prod + ((2*ZW+2)'(1) << (F - 1))) >> F);
    if (z_wide > (2*ZW+2)'(ONE)) z_wide = (2*ZW+2)'(ONE);
    if (z_wide < -(2*ZW+2)'(ONE)) z_wide = -(2*ZW+2)'(ONE);
  end

  // stage 2: radicand
  logic               s2_vld_r;
  logic signed [ZW-1:0] s2_z_r;
  logic [15:0]        s2_az_r;
  logic [SQW-1:0]     s2_n_r;
  logic [ZW-1:0]      zmag;
  assign zmag = s1_z_r[ZW-1] ? ZW'(-s1_z_r) : ZW'(s1_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_z_r  <= s1_z_r;
    s2_az_r <= s1_az_r;
    s2_n_r  <= SQW'((SQW'(1) << (2 * F)) - SQW'(zmag) * SQW'(zmag));
  end

  // square root: one result bit per stage
  logic           sq_vld_r [1:NS];
  logic [SQW-1:0] sq_n_r   [1:NS];
  logic [SQW-1:0] sq_res_r [1:NS];
  logic signed [ZW-1:0] sq_z_r [1:NS];
  logic [15:0]    sq_az_r  [1:NS];

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int BP = 2 * (NS - 1 - k);
    logic                 vld_in;
    logic [SQW-1:0]       n_in;
    logic [SQW-1:0]       res_in;
    logic signed [ZW-1:0] zp_in;
    logic [15:0]          az_in;
    logic [SQW:0]         trial;
    if (k == 0) begin : g_first
      assign vld_in = s2_vld_r;
      assign n_in   = s2_n_r;
      assign res_in = '0;
      assign zp_in  = s2_z_r;
      assign az_in  = s2_az_r;
    end else begin : g_next
      assign vld_in = sq_vld_r[k];
      assign n_in   = sq_n_r[k];
      assign res_in = sq_res_r[k];
      assign zp_in  = sq_z_r[k];
      assign az_in  = sq_az_r[k];
    end
    assign trial = (SQW+1)'(res_in) + ((SQW+1)'(1) << BP);
    always_ff @(posedge clk) begin
      if (!rst_n) sq_vld_r[k+1] <= 1'b0;
      else        sq_vld_r[k+1] <= vld_in;
      sq_z_r[k+1]  <= zp_in;
      sq_az_r[k+1] <= az_in;
      if ((SQW+1)'(n_in) >= trial) begin
        sq_n_r[k+1]   <= SQW'((SQW+1)'(n_in) - trial);
        sq_res_r[k+1] <= SQW'((res_in >> 1) + (SQW'(1) << BP));
      end else begin
        sq_n_r[k+1]   <= n_in;
        sq_res_r[k+1] <= res_in >> 1;
      end
    end
  end

  assign out_vld  = sq_vld_r[NS];
  assign z_out    = sq_z_r[NS];
  assign r_out    = RW'(sq_res_r[NS]);
  assign azim_out = sq_az_r[NS];
endmodule

@@ hw/rtl/uscsw_queue.sv @@
// Short queue between front and back parts, one word per entry.
// No package dependencies.
module uscsw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic             rd_vld,
  output logic [WIDTH-1:0] rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign rd_vld  = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : AW'(wp_r + 1'b1);
      if (rd_en && rd_vld) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : AW'(rp_r + 1'b1);
      cnt_r <= (AW+1)'(cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en && rd_vld));
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
endmodule

@@ hw/rtl/uscsw_back.sv @@
// Back part: gain scaling, pipelined CORDIC rotation, quadrant fold, output clamp.
// Uses uscsw_pkg for the gain and arctangent table.
module uscsw_back #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic signed [FRAC_BITS+1:0] z_in,
  input  logic [FRAC_BITS:0]          r_in,
  input  logic [15:0]                 azim_in,
  output logic                        out_strobe,
  output logic signed [17:0]          dir_x,
  output logic signed [17:0]          dir_y,
  output logic signed [17:0]          dir_z
);
  localparam int F  = FRAC_BITS;
  localparam int ZW = F + 2;
  localparam int XW = F + 4;
  localparam int NC = (CORDIC_STAGES < uscsw_pkg::AngleTableLen) ?
                      CORDIC_STAGES : uscsw_pkg::AngleTableLen;

  function automatic logic [17:0] to_field(input logic signed [XW-1:0] v);
    logic [XW-1:0] mag;
    logic signed [XW:0] q;
    mag = v[XW-1] ? XW'(-v) : XW'(v);
    if (F <= 16) begin
      q = (XW+1)'(v) <<< (16 - F);
    end else begin
      mag = XW'((mag + (XW'(1) << (F - 17))) >> (F - 16));
      q = v[XW-1] ? -(XW+1)'(mag) : (XW+1)'(mag);
    end
    if (q > (XW+1)'(65536)) q = (XW+1)'(65536);
    if (q < -(XW+1)'(65536)) q = -(XW+1)'(65536);
    return 18'(q);
  endfunction

  // gain stage
  logic               g_vld_r;
  logic signed [XW-1:0] g_x_r;
  logic signed [ZW-1:0] g_z_r;
  logic [15:0]        g_az_r;
  logic [F+33:0]      gprod;
  assign gprod = (F+34)'(r_in) * (F+34)'(uscsw_pkg::GainQ32) + ((F+34)'(1) << 31);

  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else        g_vld_r <= in_vld;
    g_x_r  <= XW'(gprod >> 32);
    g_z_r  <= z_in;
    g_az_r <= azim_in;
  end

  logic               c_vld_r [1:NC];
  logic signed [XW-1:0] c_x_r [1:NC];
  logic signed [XW-1:0] c_y_r [1:NC];
  logic signed [32:0] c_a_r   [1:NC];
  logic [1:0]         c_q_r   [1:NC];
  logic signed [ZW-1:0] c_z_r [1:NC];

  // The angle inside the quadrant, turns scaled by 2^32.
  logic signed [32:0] ang0;
  assign ang0 = 33'({2'b00, g_az_r[13:0], 16'h0000});

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic                 v_in;
    logic signed [XW-1:0] x_in, y_in;
    logic signed [32:0]   a_in;
    logic [1:0]           q_in;
    logic signed [ZW-1:0] zp_in;
    logic signed [XW-1:0] dx, dy;
    logic signed [32:0] at;
    if (i == 0) begin : g_first
      assign v_in  = g_vld_r;
      assign x_in  = g_x_r;
      assign y_in  = '0;
      assign a_in  = ang0;
      assign q_in  = g_az_r[15:14];
      assign zp_in = g_z_r;
    end else begin : g_next
      assign v_in  = c_vld_r[i];
      assign x_in  = c_x_r[i];
      assign y_in  = c_y_r[i];
      assign a_in  = c_a_r[i];
      assign q_in  = c_q_r[i];
      assign zp_in = c_z_r[i];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = 33'(uscsw_pkg::AtanTurnsQ32[i]);
    always_ff @(posedge clk) begin
      if (!rst_n) c_vld_r[i+1] <= 1'b0;
      else        c_vld_r[i+1] <= v_in;
      c_q_r[i+1] <= q_in;
      c_z_r[i+1] <= zp_in;
      if (!a_in[32]) begin
        c_x_r[i+1] <= x_in - dx;
        c_y_r[i+1] <= y_in + dy;
        c_a_r[i+1] <= a_in - at;
      end else begin
        c_x_r[i+1] <= x_in + dx;
        c_y_r[i+1] <= y_in - dy;
        c_a_r[i+1] <= a_in + at;
      end
    end
  end

  logic signed [XW-1:0] ox, oy, xe, ye;
  logic signed [XW-1:0] ze;
  assign xe = c_x_r[NC];
  assign ye = c_y_r[NC];
  assign ze = XW'(c_z_r[NC]);

  always_comb begin
    unique case (c_q_r[NC])
      2'd0: begin ox = xe;  oy = ye;  end
      2'd1: begin ox = -ye; oy = xe;  end
      2'd2: begin ox = -xe; oy = -ye; end
      default: begin ox = ye; oy = -xe; end
    endcase
  end

  logic        o_vld_r;
  logic [17:0] o_x_r, o_y_r, o_z_r;
  always_ff @(posedge clk) begin
    if (!rst_n) o_vld_r <= 1'b0;
    else        o_vld_r <= c_vld_r[NC];
    o_x_r <= to_field(ox);
    o_y_r <= to_field(oy);
    o_z_r <= to_field(ze);
  end

  assign out_strobe = o_vld_r;
  assign dir_x = o_x_r;
  assign dir_y = o_y_r;
  assign dir_z = o_z_r;
endmodule

@@ hw/rtl/uniform_sphere_cap_sample_warp.sv @@
// Uniform spherical cap sampler: two fractions in, one unit direction word out.
// Throughput one word per cycle; busy never rises since the receiver cannot stall.
// The path is FRAC_BITS+4 front stages (square root digit per stage), the queue entry,
// then CORDIC_STAGES+2 back stages, with the CORDIC stages capped at the table length.
// Synchronous active-low reset clears all valid bits and sets the cap to -1.0.
// Depends on uscsw_pkg, uscsw_front, uscsw_queue and uscsw_back.
module uniform_sphere_cap_sample_warp #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_u_height,
  input  logic [15:0]        in_u_azimuth,
  output logic               out_strobe,
  output logic signed [17:0] out_dir_x,
  output logic signed [17:0] out_dir_y,
  output logic signed [17:0] out_dir_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [17:0] cfg_cap_cos_limit
);
  localparam int F  = FRAC_BITS;
  localparam int QW = (F + 2) + (F + 1) + 16;

  // Cap register is written any time; host must only write while idle (not enforced).
  logic signed [17:0] cap_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= uscsw_pkg::CapMin;
    else if (cfg_valid) cap_r <= cfg_cap_cos_limit;
  end

  // The back part drains every cycle, so the input is never refused.
  assign busy = 1'b0;

  logic                 f_vld;
  logic signed [F+1:0]  f_z;
  logic [F:0]           f_r;
  logic [15:0]          f_az;

  uscsw_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(start && !busy), .cap_cos(cap_r),
    .u_height(in_u_height), .u_azimuth(in_u_azimuth),
    .out_vld(f_vld), .z_out(f_z), .r_out(f_r), .azim_out(f_az)
  );

  // The queue decouples the two halves; the back side pops whenever a word waits.
  logic          q_vld;
  logic [QW-1:0] q_data;
  uscsw_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(f_vld), .wr_data({f_z, f_r, f_az}),
    .rd_en(1'b1), .rd_vld(q_vld), .rd_data(q_data)
  );

  uscsw_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(q_vld),
    .z_in(q_data[QW-1 -: F+2]), .r_in(q_data[16 +: F+1]), .azim_in(q_data[15:0]),
    .out_strobe(out_strobe), .dir_x(out_dir_x), .dir_y(out_dir_y), .dir_z(out_dir_z)
  );
endmodule
